### rtl/fcu_pkg.sv
`timescale 1ns / 1ps
// fcu_pkg: shared types, codes and helper functions of the float calculator
// used by fcu_ctrl, fcu_datapath and float_calculator_unit; no dependencies
package fcu_pkg;

   // longest power loop, in multiplications
   localparam int unsigned MAX_LOOP = 4095;
   // loop counter width, holds any loop count up to 2^25
   localparam int LOOP_W = 26;
   // factorial index width
   localparam int FACT_W = 7;
   // wide significand and internal exponent widths
   localparam int MW = 51;
   localparam int EW = 11;

   localparam logic [2:0] CMD_ADD  = 3'd0;
   localparam logic [2:0] CMD_SUB  = 3'd1;
   localparam logic [2:0] CMD_MUL  = 3'd2;
   localparam logic [2:0] CMD_DIV  = 3'd3;
   localparam logic [2:0] CMD_POW  = 3'd4;
   localparam logic [2:0] CMD_FACT = 3'd5;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
   localparam logic signed [EW-1:0] EMIN = -11'sd126;

   typedef enum logic [1:0] {
      FOP_ADD,
      FOP_MUL,
      FOP_DIV
   } fcu_fop_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ITER,
      ST_UNPACK,
      ST_EXEC,
      ST_SUM,
      ST_DIVIDE,
      ST_LZC,
      ST_LSHIFT,
      ST_RSHIFT,
      ST_ROUND,
      ST_DONE
   } fcu_state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic iter;
      logic unpack;
      logic exec;
      logic sum;
      logic div_step;
      logic lzc;
      logic lshift;
      logic rshift;
      logic round;
      logic emit;
   } fcu_cmd_type;

   typedef struct packed {
      logic        more;
      logic        special;
      fcu_fop_type fop;
      logic        div_done;
      logic        out_free;
   } fcu_status_type;

   typedef struct packed {
      logic                 s;
      logic signed [EW-1:0] e;
      logic [23:0]          m;
   } fcu_unp_type;

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      n = 5'd24;
      for (int k = 0; k < 24; k++) begin
         if (v[k]) begin
            n = 5'(23 - k);
         end
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc_wide(input logic [MW-1:0] v);
      logic [5:0] n;
      n = 6'(MW);
      for (int k = 0; k < MW; k++) begin
         if (v[k]) begin
            n = 6'(MW - 1 - k);
         end
      end
      return n;
   endfunction

   // small nonzero integer to binary32
   function automatic logic [31:0] int_to_float(input logic [FACT_W-1:0] v);
      logic [2:0]  p;
      logic [22:0] f;
      p = 3'd0;
      for (int k = 0; k < FACT_W; k++) begin
         if (v[k]) begin
            p = 3'(k);
         end
      end
      f = 23'(v) << (5'd23 - {2'b00, p});
      return {1'b0, 8'(8'd127 + {5'b00000, p}), f};
   endfunction

endpackage

### rtl/fcu_ctrl.sv
`timescale 1ns / 1ps
// fcu_ctrl: sequencing state machine of the float calculator
// depends on fcu_pkg; drives fcu_datapath through command and status structs
module fcu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fcu_pkg::fcu_status_type status,
   output fcu_pkg::fcu_cmd_type   cmd
);

   fcu_pkg::fcu_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcu_pkg::ST_IDLE: begin
            if (req_valid) state_in = fcu_pkg::ST_SETUP;
         end
         fcu_pkg::ST_SETUP:  state_in = fcu_pkg::ST_ITER;
         fcu_pkg::ST_ITER: begin
            state_in = status.more ? fcu_pkg::ST_UNPACK : fcu_pkg::ST_DONE;
         end
         fcu_pkg::ST_UNPACK: state_in = fcu_pkg::ST_EXEC;
         fcu_pkg::ST_EXEC: begin
            if (status.special) begin
               state_in = fcu_pkg::ST_ITER;
            end else begin
               case (status.fop)
                  fcu_pkg::FOP_ADD: state_in = fcu_pkg::ST_SUM;
                  fcu_pkg::FOP_DIV: state_in = fcu_pkg::ST_DIVIDE;
                  default:          state_in = fcu_pkg::ST_LZC;
               endcase
            end
         end
         fcu_pkg::ST_SUM:    state_in = fcu_pkg::ST_LZC;
         fcu_pkg::ST_DIVIDE: begin
            if (status.div_done) state_in = fcu_pkg::ST_LZC;
         end
         fcu_pkg::ST_LZC:    state_in = fcu_pkg::ST_LSHIFT;
         fcu_pkg::ST_LSHIFT: state_in = fcu_pkg::ST_RSHIFT;
         fcu_pkg::ST_RSHIFT: state_in = fcu_pkg::ST_ROUND;
         fcu_pkg::ST_ROUND:  state_in = fcu_pkg::ST_ITER;
         fcu_pkg::ST_DONE: begin
            if (status.out_free) state_in = fcu_pkg::ST_IDLE;
         end
         default:            state_in = fcu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         fcu_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         fcu_pkg::ST_SETUP:  cmd.setup    = 1'b1;
         fcu_pkg::ST_ITER:   cmd.iter     = 1'b1;
         fcu_pkg::ST_UNPACK: cmd.unpack   = 1'b1;
         fcu_pkg::ST_EXEC:   cmd.exec     = 1'b1;
         fcu_pkg::ST_SUM:    cmd.sum      = 1'b1;
         fcu_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         fcu_pkg::ST_LZC:    cmd.lzc      = 1'b1;
         fcu_pkg::ST_LSHIFT: cmd.lshift   = 1'b1;
         fcu_pkg::ST_RSHIFT: cmd.rshift   = 1'b1;
         fcu_pkg::ST_ROUND:  cmd.round    = 1'b1;
         fcu_pkg::ST_DONE:   cmd.emit     = status.out_free;
         default:            cmd          = '0;
      endcase
   end

endmodule

### rtl/fcu_datapath.sv
`timescale 1ns / 1ps
// fcu_datapath: operand registers, shared add/multiply/divide float unit,
// normalize and round stages, loop counters and result register; uses fcu_pkg
module fcu_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  fcu_pkg::fcu_cmd_type    cmd,
   output fcu_pkg::fcu_status_type status,
   input  logic [2:0]              req_command,
   input  logic                    req_vector_mode,
   input  logic [31:0]             req_operand_a,
   input  logic [31:0]             req_operand_b,
   input  logic                    req_last_element,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [31:0]             rsp_value,
   output logic                    rsp_unsupported,
   output logic                    rsp_range_flag,
   output logic                    rsp_end_of_vector
);

   localparam int EW = fcu_pkg::EW;
   localparam int MW = fcu_pkg::MW;
   localparam int LW = fcu_pkg::LOOP_W;
   localparam int FW = fcu_pkg::FACT_W;

   function automatic fcu_pkg::fcu_unp_type unpack(input logic [31:0] v);
      fcu_pkg::fcu_unp_type u;
      logic [23:0]          m0;
      logic signed [EW-1:0] e0;
      logic [4:0]           lz;
      m0 = {(v[30:23] != 8'd0), v[22:0]};
      e0 = (v[30:23] == 8'd0) ? fcu_pkg::EMIN : ($signed({3'b000, v[30:23]}) - 11'sd127);
      lz = fcu_pkg::lzc24(m0);
      u.s = v[31];
      u.m = m0 << lz;
      u.e = e0 - $signed({6'b000000, lz});
      return u;
   endfunction

   // item registers
   logic [2:0]  op_ff, op_in;
   logic        vec_ff, vec_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic        last_ff, last_in;
   logic        unsup_ff, unsup_in, range_ff, range_in;
   logic        pending_ff, pending_in, pow_ff, pow_in, fact_ff, fact_in;
   logic [LW-1:0] n_ff, n_in;
   logic [FW-1:0] i_ff, i_in, lim_ff, lim_in;
   logic [31:0] r_ff, r_in;
   // current float operation
   logic [31:0] x_ff, x_in, y_ff, y_in;
   fcu_pkg::fcu_fop_type fop_ff, fop_in;
   fcu_pkg::fcu_unp_type xu_ff, xu_in, yu_ff, yu_in;
   logic        special_ff, special_in;
   logic [31:0] spec_ff, spec_in;
   // wide working value
   logic                 s_ff, s_in;
   logic signed [EW-1:0] e_ff, e_in;
   logic [MW-1:0]        m_ff, m_in, am_ff, am_in, bm_ff, bm_in;
   logic                 st_ff, st_in, sub_ff, sub_in;
   logic [5:0]           lz_ff, lz_in;
   logic [26:0]          q_ff, q_in;
   logic [24:0]          rem_ff, rem_in;
   logic [4:0]           dcnt_ff, dcnt_in;
   // result register
   logic        rv_ff, rv_in, ru_ff, ru_in, rr_ff, rr_in, re_ff, re_in;
   logic [31:0] rval_ff, rval_in;

   // setup helpers
   logic [7:0]    bexp, aexp;
   logic [23:0]   bman, aman, fmask;
   logic [4:0]    ebit;
   logic [LW-1:0] ipart, cnt;
   logic          big, le1, bnan, anan, frac_nz, rng;
   // float unit helpers
   logic          xnan, ynan, xinf, yinf, xzero, yzero;
   logic          xbig;
   fcu_pkg::fcu_unp_type bu, su;
   logic signed [EW-1:0] dexp, rsh;
   logic [5:0]    dsh;
   logic [MW-1:0] sw, shv, wsum;
   logic [24:0]   rem_n;
   logic          ge;
   logic [26:0]   q_n;
   logic [47:0]   prod;
   logic [7:0]    rexp;
   logic [30:0]   rbase;
   logic          rinc;

   assign xnan  = (x_ff[30:23] == 8'hFF) && (x_ff[22:0] != 23'd0);
   assign ynan  = (y_ff[30:23] == 8'hFF) && (y_ff[22:0] != 23'd0);
   assign xinf  = (x_ff[30:0] == 31'h7F80_0000);
   assign yinf  = (y_ff[30:0] == 31'h7F80_0000);
   assign xzero = (x_ff[30:0] == 31'd0);
   assign yzero = (y_ff[30:0] == 31'd0);

   always_comb begin
      status.more = pending_ff || (pow_ff && (n_ff != '0)) ||
                    (fact_ff && (r_ff[30:0] != 31'h7F80_0000) && (i_ff <= lim_ff));
      status.special  = special_ff;
      status.fop      = fop_ff;
      status.div_done = (dcnt_ff == 5'd0);
      status.out_free = !rv_ff || !rsp_stall;
   end

   always_comb begin
      op_in = op_ff; vec_in = vec_ff; a_in = a_ff; b_in = b_ff; last_in = last_ff;
      unsup_in = unsup_ff; range_in = range_ff; pending_in = pending_ff;
      pow_in = pow_ff; fact_in = fact_ff; n_in = n_ff; i_in = i_ff; lim_in = lim_ff;
      r_in = r_ff; x_in = x_ff; y_in = y_ff; fop_in = fop_ff;
      xu_in = xu_ff; yu_in = yu_ff; special_in = special_ff; spec_in = spec_ff;
      s_in = s_ff; e_in = e_ff; m_in = m_ff; am_in = am_ff; bm_in = bm_ff;
      st_in = st_ff; sub_in = sub_ff; lz_in = lz_ff; q_in = q_ff; rem_in = rem_ff;
      dcnt_in = dcnt_ff;
      rv_in = rv_ff && rsp_stall; ru_in = ru_ff; rr_in = rr_ff; re_in = re_ff;
      rval_in = rval_ff;

      // power loop count: integers i with 1 <= i < b
      bexp  = b_ff[30:23];
      bman  = {1'b1, b_ff[22:0]};
      bnan  = (bexp == 8'hFF) && (b_ff[22:0] != 23'd0);
      le1   = b_ff[31] || (b_ff[30:0] <= 31'h3F80_0000);
      big   = (bexp >= 8'd152);
      ebit  = 5'(bexp - 8'd127);
      fmask = (ebit <= 5'd23) ? ((24'd1 << (5'd23 - ebit)) - 24'd1) : 24'd0;
      frac_nz = (bman & fmask) != 24'd0;
      ipart = (ebit <= 5'd23) ? LW'(bman >> (5'd23 - ebit)) : (LW'(bman) << 1);
      cnt   = ipart + LW'(frac_nz) - LW'(1);
      if (bnan || le1) begin
         cnt = '0;
         big = 1'b0;
      end
      rng = big || (cnt > LW'(fcu_pkg::MAX_LOOP));
      // factorial upper index, floor of a, capped at 63
      aexp = a_ff[30:23];
      aman = {1'b1, a_ff[22:0]};
      anan = (aexp == 8'hFF) && (a_ff[22:0] != 23'd0);

      // float unit operand ordering for add
      xbig = (xu_ff.e > yu_ff.e) || ((xu_ff.e == yu_ff.e) && (xu_ff.m >= yu_ff.m));
      bu   = xbig ? xu_ff : yu_ff;
      su   = xbig ? yu_ff : xu_ff;
      dexp = bu.e - su.e;
      dsh  = (dexp > 11'sd63) ? 6'd63 : dexp[5:0];
      sw   = {1'b0, su.m, 26'd0};
      shv  = sw >> dsh;
      prod = xu_ff.m * yu_ff.m;
      wsum = sub_ff ? (am_ff - bm_ff) : (am_ff + bm_ff);
      ge    = rem_ff >= {1'b0, yu_ff.m};
      rem_n = ge ? (rem_ff - {1'b0, yu_ff.m}) : rem_ff;
      q_n   = {q_ff[25:0], ge};
      rsh   = fcu_pkg::EMIN - e_ff;
      rexp  = m_ff[MW-1] ? 8'(e_ff + 11'sd127) : 8'd0;
      rbase = {rexp, m_ff[MW-2:MW-24]};
      rinc  = m_ff[MW-25] && ((|m_ff[MW-26:0]) || st_ff || m_ff[MW-24]);

      if (cmd.load) begin
         op_in   = req_command;
         vec_in  = req_vector_mode;
         a_in    = req_operand_a;
         b_in    = req_operand_b;
         last_in = req_last_element;
      end

      if (cmd.setup) begin
         unsup_in   = (op_ff > fcu_pkg::CMD_FACT) || (vec_ff && (op_ff > fcu_pkg::CMD_MUL));
         pending_in = !unsup_in && (op_ff <= fcu_pkg::CMD_DIV);
         pow_in     = !unsup_in && (op_ff == fcu_pkg::CMD_POW);
         fact_in    = !unsup_in && (op_ff == fcu_pkg::CMD_FACT);
         i_in       = FW'(1);
         range_in   = 1'b0;
         n_in       = '0;
         if (a_ff[31] || (aexp < 8'd127) || anan) begin
            lim_in = '0;
         end else if (aexp >= 8'd133) begin
            lim_in = FW'(63);
         end else begin
            lim_in = FW'(aman >> (8'd150 - aexp));
         end
         if (fact_in) begin
            r_in = fcu_pkg::ONE_BITS;
         end else if (pow_in) begin
            if (b_ff[30:0] == 31'd0) begin
               r_in = fcu_pkg::ONE_BITS;
            end else begin
               r_in     = a_ff;
               range_in = rng;
               n_in     = rng ? LW'(fcu_pkg::MAX_LOOP) : cnt;
            end
         end
      end

      if (cmd.iter && status.more) begin
         fop_in = fcu_pkg::FOP_MUL;
         if (pending_ff) begin
            pending_in = 1'b0;
            x_in = a_ff;
            y_in = (op_ff == fcu_pkg::CMD_SUB) ? {~b_ff[31], b_ff[30:0]} : b_ff;
            case (op_ff)
               fcu_pkg::CMD_ADD, fcu_pkg::CMD_SUB: fop_in = fcu_pkg::FOP_ADD;
               fcu_pkg::CMD_DIV:                   fop_in = fcu_pkg::FOP_DIV;
               default:                            fop_in = fcu_pkg::FOP_MUL;
            endcase
         end else if (pow_ff) begin
            x_in = r_ff;
            y_in = a_ff;
            n_in = n_ff - LW'(1);
         end else begin
            x_in = r_ff;
            y_in = fcu_pkg::int_to_float(i_ff);
            i_in = i_ff + FW'(1);
         end
      end

      if (cmd.unpack) begin
         xu_in      = unpack(x_ff);
         yu_in      = unpack(y_ff);
         special_in = 1'b1;
         spec_in    = fcu_pkg::CANON_NAN;
         case (fop_ff)
            fcu_pkg::FOP_ADD: begin
               if (xnan || ynan || (xinf && yinf && (x_ff[31] != y_ff[31]))) begin
                  spec_in = fcu_pkg::CANON_NAN;
               end else if (xinf) begin
                  spec_in = x_ff;
               end else if (yinf) begin
                  spec_in = y_ff;
               end else if (xzero && yzero) begin
                  spec_in = {x_ff[31] & y_ff[31], 31'd0};
               end else if (xzero) begin
                  spec_in = y_ff;
               end else if (yzero) begin
                  spec_in = x_ff;
               end else begin
                  special_in = 1'b0;
               end
            end
            fcu_pkg::FOP_MUL: begin
               if (xnan || ynan || (xinf && yzero) || (yinf && xzero)) begin
                  spec_in = fcu_pkg::CANON_NAN;
               end else if (xinf || yinf) begin
                  spec_in = {x_ff[31] ^ y_ff[31], 31'h7F80_0000};
               end else if (xzero || yzero) begin
                  spec_in = {x_ff[31] ^ y_ff[31], 31'd0};
               end else begin
                  special_in = 1'b0;
               end
            end
            default: begin
               if (xnan || ynan || (xzero && yzero) || (xinf && yinf)) begin
                  spec_in = fcu_pkg::CANON_NAN;
               end else if (xinf || yzero) begin
                  spec_in = {x_ff[31] ^ y_ff[31], 31'h7F80_0000};
               end else if (xzero || yinf) begin
                  spec_in = {x_ff[31] ^ y_ff[31], 31'd0};
               end else begin
                  special_in = 1'b0;
               end
            end
         endcase
      end

      if (cmd.exec) begin
         st_in = 1'b0;
         if (special_ff) begin
            r_in = spec_ff;
         end else begin
            case (fop_ff)
               fcu_pkg::FOP_ADD: begin
                  am_in  = {1'b0, bu.m, 26'd0};
                  bm_in  = shv | MW'((shv << dsh) != sw);
                  e_in   = bu.e + 11'sd1;
                  s_in   = bu.s;
                  sub_in = xu_ff.s ^ yu_ff.s;
               end
               fcu_pkg::FOP_DIV: begin
                  q_in    = '0;
                  rem_in  = {1'b0, xu_ff.m};
                  dcnt_in = 5'd26;
                  s_in    = xu_ff.s ^ yu_ff.s;
                  e_in    = xu_ff.e - yu_ff.e;
               end
               default: begin
                  m_in = {prod, 3'b000};
                  e_in = xu_ff.e + yu_ff.e + 11'sd1;
                  s_in = xu_ff.s ^ yu_ff.s;
               end
            endcase
         end
      end

      if (cmd.sum) begin
         m_in = wsum;
         if (wsum == '0) s_in = 1'b0;
      end

      if (cmd.div_step) begin
         q_in    = q_n;
         rem_in  = {rem_n[23:0], 1'b0};
         dcnt_in = dcnt_ff - 5'd1;
         if (dcnt_ff == 5'd0) begin
            m_in  = {q_n, 24'd0};
            st_in = rem_n != 25'd0;
         end
      end

      if (cmd.lzc) begin
         lz_in = (m_ff == '0) ? 6'd0 : fcu_pkg::lzc_wide(m_ff);
      end

      if (cmd.lshift) begin
         m_in = m_ff << lz_ff;
         e_in = e_ff - $signed({5'd0, lz_ff});
      end

      if (cmd.rshift && (e_ff < fcu_pkg::EMIN)) begin
         m_in  = m_ff >> ((rsh > 11'sd63) ? 6'd63 : rsh[5:0]);
         st_in = st_ff || ((m_in << ((rsh > 11'sd63) ? 6'd63 : rsh[5:0])) != m_ff);
         e_in  = fcu_pkg::EMIN;
      end

      if (cmd.round) begin
         if (m_ff[MW-1] && (e_ff >= 11'sd128)) begin
            r_in = {s_ff, 31'h7F80_0000};
         end else begin
            r_in = {s_ff, rbase + 31'(rinc)};
         end
      end

      if (cmd.emit) begin
         rv_in = 1'b1;
         ru_in = unsup_ff;
         rr_in = range_ff && !unsup_ff;
         re_in = last_ff;
         if (unsup_ff) begin
            rval_in = 32'd0;
         end else if ((r_ff[30:23] == 8'hFF) && (r_ff[22:0] != 23'd0)) begin
            rval_in = fcu_pkg::CANON_NAN;
         end else begin
            rval_in = r_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
      end
      op_ff <= op_in; vec_ff <= vec_in; a_ff <= a_in; b_ff <= b_in; last_ff <= last_in;
      unsup_ff <= unsup_in; range_ff <= range_in; pending_ff <= pending_in;
      pow_ff <= pow_in; fact_ff <= fact_in; n_ff <= n_in; i_ff <= i_in; lim_ff <= lim_in;
      r_ff <= r_in; x_ff <= x_in; y_ff <= y_in; fop_ff <= fop_in;
      xu_ff <= xu_in; yu_ff <= yu_in; special_ff <= special_in; spec_ff <= spec_in;
      s_ff <= s_in; e_ff <= e_in; m_ff <= m_in; am_ff <= am_in; bm_ff <= bm_in;
      st_ff <= st_in; sub_ff <= sub_in; lz_ff <= lz_in; q_ff <= q_in; rem_ff <= rem_in;
      dcnt_ff <= dcnt_in;
      ru_ff <= ru_in; rr_ff <= rr_in; re_ff <= re_in; rval_ff <= rval_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_value         = rval_ff;
   assign rsp_unsupported   = ru_ff;
   assign rsp_range_flag    = rr_ff;
   assign rsp_end_of_vector = re_ff;

endmodule

### rtl/float_calculator_unit.sv
`timescale 1ns / 1ps
// each float op: unpack, exec, sum for add or divide for divide (one quotient bit
// a cycle), leading-zero count, shifts and round; power and factorial run n
// multiplications, n at most MAX_LOOP for power and 35 for factorial; special
// operands finish early. One item at a time: the next item is taken in the
// cycle after the result is loaded, while it may still wait in the output register
// reset: synchronous, active high; clears the sequencer and the output valid
module float_calculator_unit (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic        req_vector_mode,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic        req_last_element,
   // result item channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic        rsp_unsupported,
   output logic        rsp_range_flag,
   output logic        rsp_end_of_vector
);

   // commands from the sequencer, status back from the datapath
   fcu_pkg::fcu_cmd_type    cmd;
   fcu_pkg::fcu_status_type status;

   // sequencer: setup, loop control, float op steps, result hand-off
   fcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: operand capture, shared float unit, round, output register
   fcu_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_command),
      .req_vector_mode   (req_vector_mode),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .req_last_element  (req_last_element),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_unsupported   (rsp_unsupported),
      .rsp_range_flag    (rsp_range_flag),
      .rsp_end_of_vector (rsp_end_of_vector)
   );

endmodule

### rtl/fcu_checker.sv
`timescale 1ns / 1ps
// fcu_checker: port-level assertions for float_calculator_unit
// attached by the bind below; no package dependency
module fcu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_value,
   input logic        rsp_unsupported,
   input logic        rsp_range_flag
);

   // a held result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled result changed");

   // one item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted item while busy");

   // rejected command gives zero value and no range flag
   a_unsup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unsupported |-> rsp_value == 32'd0 && !rsp_range_flag)
      else $error("unsupported result not cleared");

   // nan results are canonical
   a_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value[30:23] == 8'hFF && rsp_value[22:0] != 23'd0
      |-> rsp_value == 32'h7FC0_0000)
      else $error("non-canonical nan");

endmodule

bind float_calculator_unit fcu_checker u_fcu_checker (.*);

### tb/float_calculator_unit_tb.sv
`timescale 1ns / 1ps
// float_calculator_unit_tb: self-checking bench for the float calculator,
// with a binary32 predictor built on real arithmetic; depends on fcu_pkg
module float_calculator_unit_tb;

   // command codes the block must reject in either mode
   localparam logic [2:0] CMD_RSVD_LO = 3'd6;
   localparam logic [2:0] CMD_RSVD_HI = 3'd7;
   localparam logic [31:0] POS_INF = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF = 32'hFF80_0000;
   localparam logic [31:0] MAX_NORM = 32'h7F7F_FFFF;
   localparam logic [31:0] MIN_SUB = 32'h0000_0001;
   localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
   localparam int RANDOM_ITEMS = 1500;
   localparam int PAUSE_AT = 400;
   localparam int CALM_LO = 700;
   localparam int CALM_HI = 900;

   typedef struct {
      logic [2:0]  command;
      logic        vector_mode;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
      logic        last_element;
   } calc_item_type;

   typedef struct {
      logic [31:0] value;
      logic        unsupported;
      logic        range_flag;
      logic        end_of_vector;
   } calc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic        req_vector_mode = 1'b0;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic        req_last_element = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [31:0] rsp_value;
   logic        rsp_unsupported;
   logic        rsp_range_flag;
   logic        rsp_end_of_vector;

   calc_item_type   pending_items[$];
   calc_result_type expected_results[$];
   int              accepted_count = 0;
   int              returned_count = 0;
   int              mismatch_count = 0;

   float_calculator_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_vector_mode(req_vector_mode), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_value(rsp_value),
      .rsp_unsupported(rsp_unsupported), .rsp_range_flag(rsp_range_flag),
      .rsp_end_of_vector(rsp_end_of_vector)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // binary32 <-> real; a double holds every float exactly, and one
   // double op rounded once more to float is still correctly rounded
   // ---------------------------------------------------------------
   function automatic real f32_to_real(input logic [31:0] f);
      logic [7:0]  ex;
      logic [22:0] fr;
      real         v;
      ex = f[30:23];
      fr = f[22:0];
      if (ex == 8'hFF) begin
         if (fr != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
         v = $bitstoreal(64'h7FF0_0000_0000_0000);
      end else if (ex == 0) begin
         v = real'(fr) * (2.0 ** -149);
      end else begin
         v = $bitstoreal({1'b0, 11'(ex - 127 + 1023), fr, 29'b0});
      end
      return f[31] ? -v : v;
   endfunction

   // round a double to binary32, nearest even, subnormals included
   function automatic logic [31:0] real_to_f32(input real x);
      logic [63:0] d, sig, q, rest;
      int          e, shift;
      logic        rbit, sticky;
      d = $realtobits(x);
      if (d[62:52] == 11'h7FF) begin
         return (d[51:0] != 0) ? fcu_pkg::CANON_NAN : {d[63], 31'h7F80_0000};
      end
      // double subnormals are far below half the smallest float
      if (d[62:52] == 0) return {d[63], 31'b0};
      e = int'(d[62:52]) - 1023;
      sig = {11'b0, 1'b1, d[51:0]};
      shift = (e >= -126) ? 29 : 29 + (-126 - e);
      if (shift > 62) shift = 62;
      q = sig >> shift;
      rbit = sig[shift-1];
      rest = sig & ((64'd1 << (shift - 1)) - 64'd1);
      sticky = (rest != 0);
      if (rbit && (sticky || q[0])) q = q + 1;
      if (e < -126) return {d[63], 31'(q)};   // carry into exponent is fine
      if (q[24]) begin
         q = q >> 1;
         e = e + 1;
      end
      if (e > 127) return {d[63], 31'h7F80_0000};
      return {d[63], 8'(e + 127), q[22:0]};
   endfunction

   function automatic logic [31:0] fmul32(input logic [31:0] x, input logic [31:0] y);
      return real_to_f32(f32_to_real(x) * f32_to_real(y));
   endfunction

   // integer power by repeated multiply, cut at MAX_LOOP
   function automatic logic [31:0] power_value(input logic [31:0] a, input logic [31:0] b,
                                               output logic cut);
      logic [31:0] r;
      real         bv;
      int unsigned i, n;
      cut = 1'b0;
      r = a;
      bv = f32_to_real(b);
      if (bv == 0.0) return fcu_pkg::ONE_BITS;
      n = 0;
      for (i = 1; real'(i) < bv; i++) begin
         if (n >= fcu_pkg::MAX_LOOP) begin
            cut = 1'b1;
            break;
         end
         r = fmul32(r, a);
         n++;
      end
      return r;
   endfunction

   function automatic logic [31:0] factorial_value(input logic [31:0] a);
      logic [31:0] r;
      real         av;
      int unsigned i;
      r = fcu_pkg::ONE_BITS;
      av = f32_to_real(a);
      for (i = 1; real'(i) <= av; i++) begin
         r = fmul32(r, real_to_f32(real'(i)));
         if (r[30:0] == 31'h7F80_0000) break;   // infinity no longer changes
      end
      return r;
   endfunction

   function automatic calc_result_type calc_predict(input calc_item_type it);
      calc_result_type res;
      real             av, bv;
      logic            cut;
      res.value = '0;
      res.unsupported = 1'b0;
      res.range_flag = 1'b0;
      res.end_of_vector = it.last_element;
      av = f32_to_real(it.operand_a);
      bv = f32_to_real(it.operand_b);
      if (it.command > fcu_pkg::CMD_FACT ||
          (it.vector_mode && it.command > fcu_pkg::CMD_MUL)) begin
         res.unsupported = 1'b1;
      end else begin
         case (it.command)
            fcu_pkg::CMD_ADD: res.value = real_to_f32(av + bv);
            fcu_pkg::CMD_SUB: res.value = real_to_f32(av - bv);
            fcu_pkg::CMD_MUL: res.value = real_to_f32(av * bv);
            fcu_pkg::CMD_DIV: res.value = real_to_f32(av / bv);
            fcu_pkg::CMD_POW: begin
               res.value = power_value(it.operand_a, it.operand_b, cut);
               res.range_flag = cut;
            end
            default: res.value = factorial_value(it.operand_a);
         endcase
         if (res.value[30:23] == 8'hFF && res.value[22:0] != 0) begin
            res.value = fcu_pkg::CANON_NAN;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   function automatic logic [31:0] pick_operand();
      logic [31:0] specials[8];
      specials = '{32'h0, NEG_ZERO, POS_INF, NEG_INF, fcu_pkg::CANON_NAN, MAX_NORM,
                   MIN_SUB, 32'hFFC1_2345};
      case ($urandom_range(9))
         0, 1, 2: return $urandom();
         3:       return specials[$urandom_range(7)];
         4:       return {1'($urandom()), 8'h00, 23'($urandom())};   // subnormal
         default: return {1'($urandom()), 8'($urandom_range(140, 114)), 23'($urandom())};
      endcase
   endfunction

   // small whole or fractional exponents keep the power loop short
   function automatic logic [31:0] pick_exponent();
      if ($urandom_range(4) == 0) return {1'($urandom()), 8'($urandom_range(128, 100)),
                                          23'($urandom())};
      return real_to_f32(real'($urandom_range(14)));
   endfunction

   function automatic calc_item_type make_item(input logic [2:0] c, input logic v,
                                               input logic [31:0] a, input logic [31:0] b,
                                               input logic l);
      calc_item_type it;
      it.command = c;
      it.vector_mode = v;
      it.operand_a = a;
      it.operand_b = b;
      it.last_element = l;
      return it;
   endfunction

   // ---------------------------------------------------------------
   // stimulus, end of run and the final verdict
   // ---------------------------------------------------------------
   initial begin
      calc_item_type it;
      int            vlen, k;
      // directed: extremes and special cases
      pending_items.push_back(make_item(fcu_pkg::CMD_ADD, 0, MAX_NORM, MAX_NORM, 1)); // overflow
      pending_items.push_back(make_item(fcu_pkg::CMD_SUB, 0, POS_INF, POS_INF, 1));   // inf - inf
      pending_items.push_back(make_item(fcu_pkg::CMD_ADD, 1, MIN_SUB, MIN_SUB, 0));   // subnormals
      pending_items.push_back(make_item(fcu_pkg::CMD_MUL, 1, 32'hFFFF_FFFF, 32'h0, 1)); // nan in
      pending_items.push_back(make_item(fcu_pkg::CMD_MUL, 0, MIN_SUB, 32'h3F00_0000, 1)); // ties
      pending_items.push_back(make_item(fcu_pkg::CMD_DIV, 0, 32'h0, NEG_ZERO, 1));    // 0 / 0
      pending_items.push_back(make_item(fcu_pkg::CMD_DIV, 0, 32'h3F80_0000, NEG_ZERO, 0)); // 1/-0
      pending_items.push_back(make_item(fcu_pkg::CMD_DIV, 0, MAX_NORM, MIN_SUB, 1));
      pending_items.push_back(make_item(fcu_pkg::CMD_POW, 0, 32'h4000_0000, 32'h0, 1)); // b zero
      pending_items.push_back(make_item(fcu_pkg::CMD_POW, 0, 32'h4000_0000, NEG_ZERO, 1));
      pending_items.push_back(make_item(fcu_pkg::CMD_POW, 0, 32'h4040_0000,
                                        fcu_pkg::CANON_NAN, 1));               // b nan
      pending_items.push_back(make_item(fcu_pkg::CMD_POW, 0, 32'h4040_0000, 32'hBF80_0000, 1));
      pending_items.push_back(make_item(fcu_pkg::CMD_POW, 0, 32'h3F80_0001, 32'h4120_0000, 1));
      pending_items.push_back(make_item(fcu_pkg::CMD_POW, 0, 32'h3F80_0000, POS_INF, 1)); // cut
      pending_items.push_back(make_item(fcu_pkg::CMD_POW, 0, 32'hBF80_0000,
                                        32'h457F_F000, 1));                    // 4095 exact
      pending_items.push_back(make_item(fcu_pkg::CMD_FACT, 0, fcu_pkg::CANON_NAN, 32'h0, 1));
      pending_items.push_back(make_item(fcu_pkg::CMD_FACT, 0, 32'h3F7F_FFFF,
                                        $urandom(), 1));                       // below one
      pending_items.push_back(make_item(fcu_pkg::CMD_FACT, 0, 32'h4120_0000, 32'h0, 1)); // 10!
      pending_items.push_back(make_item(fcu_pkg::CMD_FACT, 0, POS_INF, 32'h0, 1)); // to inf
      pending_items.push_back(make_item(fcu_pkg::CMD_DIV, 1, 32'h4000_0000, 32'h4000_0000, 0));
      pending_items.push_back(make_item(fcu_pkg::CMD_POW, 1, 32'h4000_0000, 32'h4000_0000, 0));
      pending_items.push_back(make_item(fcu_pkg::CMD_FACT, 1, 32'h4000_0000, 32'h0, 1));
      pending_items.push_back(make_item(CMD_RSVD_LO, 0, 32'h4000_0000, 32'h4000_0000, 1));
      pending_items.push_back(make_item(CMD_RSVD_HI, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      // random: mostly well-formed vectors and scalar commands
      while (pending_items.size() < RANDOM_ITEMS + 24) begin
         if ($urandom_range(3) == 0) begin
            vlen = $urandom_range(8, 1);
            for (k = 0; k < vlen; k++) begin
               it = make_item(3'($urandom_range(fcu_pkg::CMD_MUL)), 1'b1, pick_operand(),
                              pick_operand(), k == vlen - 1);
               if ($urandom_range(19) == 0) it.command = 3'($urandom_range(7, 3));
               if ($urandom_range(19) == 0) it.last_element = ~it.last_element;
               pending_items.push_back(it);
            end
         end else begin
            it = make_item(3'($urandom_range(fcu_pkg::CMD_FACT)), 1'b0, pick_operand(),
                           pick_operand(), $urandom_range(9) != 0);
            if ($urandom_range(30) == 0) it.command = 3'($urandom_range(7, 6));
            if (it.command == fcu_pkg::CMD_POW) begin
               it.operand_b = pick_exponent();
               if ($urandom_range(60) == 0) it.operand_b = real_to_f32(real'(
                                                $urandom_range(6000, 4000)));
               if ($urandom_range(1) == 0) it.operand_a = {1'($urandom()),
                  8'($urandom_range(129, 124)), 23'($urandom())};
            end
            if (it.command == fcu_pkg::CMD_FACT && $urandom_range(1) == 0) begin
               it.operand_a = real_to_f32(real'($urandom_range(40)) + 0.5 *
                                          real'($urandom_range(1)));
            end
            pending_items.push_back(it);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent, everything returned, then a short tail
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // worst case is a handful of cut power loops, each running MAX_LOOP multiplications
   initial begin
      #100ms;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------
   // driver: predicts on acceptance, then offers the next item
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      calc_item_type it;
      logic          hold;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(calc_predict(make_item(req_command,
               req_vector_mode, req_operand_a, req_operand_b, req_last_element)));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            // one pause until the block has drained completely
            hold = (accepted_count == PAUSE_AT && expected_results.size() != 0);
            // no gaps at all inside the calm window
            if (!(accepted_count >= CALM_LO && accepted_count < CALM_HI) &&
                $urandom_range(99) < 23) begin
               hold = 1'b1;
            end
            if (pending_items.size() != 0 && !hold) begin
               it = pending_items.pop_front();
               req_command <= it.command;
               req_vector_mode <= it.vector_mode;
               req_operand_a <= it.operand_a;
               req_operand_b <= it.operand_b;
               req_last_element <= it.last_element;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: random back-pressure, field by field compare
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      calc_result_type want;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            returned_count++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result item value=%h", rsp_value);
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value || rsp_unsupported !== want.unsupported ||
                   rsp_range_flag !== want.range_flag ||
                   rsp_end_of_vector !== want.end_of_vector) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result %0d: expected %h/%b/%b/%b got %h/%b/%b/%b",
                              returned_count, want.value, want.unsupported,
                              want.range_flag, want.end_of_vector, rsp_value,
                              rsp_unsupported, rsp_range_flag, rsp_end_of_vector);
                  end
               end
            end
         end
         rsp_stall <= !(returned_count >= CALM_LO && returned_count < CALM_HI) &&
                      ($urandom_range(99) < 23);
      end
   end

endmodule

### filelist.f
rtl/fcu_pkg.sv
rtl/fcu_ctrl.sv
rtl/fcu_datapath.sv
rtl/float_calculator_unit.sv
rtl/fcu_checker.sv
tb/float_calculator_unit_tb.sv
